### rtl/core/sttscan_pkg.sv
// ----------------------------------------------------------------------------
// sttscan_pkg
// shared types, constants and the command pattern table of the script
// token threshold scanner
// ----------------------------------------------------------------------------
package sttscan_pkg;

  localparam int WINDOW_BYTES = 23;
  localparam int BYTE_W       = 8;
  localparam int WIN_W        = WINDOW_BYTES * BYTE_W;
  localparam int HIST_W       = (WINDOW_BYTES - 1) * BYTE_W;
  localparam int PAT_COUNT    = 10;
  localparam int THR_W        = 4;
  localparam int LIMIT_W      = 21;
  localparam int COUNT_W      = 4;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(2);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024 * 1024);

  // register index, taken from the word address
  typedef enum logic {
    REG_THRESHOLD  = 1'b0,
    REG_SCAN_LIMIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [THR_W-1:0]   match_threshold;
    logic [LIMIT_W-1:0] scan_limit;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data_byte;
    logic              last;
  } step_t;

  typedef struct packed {
    logic                 suspicious;
    logic [PAT_COUNT-1:0] match_mask;
    logic [COUNT_W-1:0]   match_count;
  } result_t;

  // patterns right aligned: final character in the lowest byte
  localparam logic [WIN_W-1:0] PAT_TEXT [PAT_COUNT] = '{
    WIN_W'("invoke-expression"),
    WIN_W'("iex "),
    WIN_W'("downloadstring"),
    WIN_W'("downloadfile"),
    WIN_W'("-encodedcommand"),
    WIN_W'(" -enc "),
    WIN_W'("frombase64string"),
    WIN_W'("-windowstyle hidden"),
    WIN_W'("-executionpolicy bypass"),
    WIN_W'("net.webclient")
  };

  localparam int PAT_LEN [PAT_COUNT] = '{17, 4, 14, 12, 15, 6, 16, 19, 23, 13};

  // compare mask over the newest len bytes of the window
  function automatic logic [WIN_W-1:0] pat_mask(input int len);
    logic [WIN_W-1:0] m;
    m = '0;
    for (int b = 0; b < WIN_W; b++) begin
      if (b < BYTE_W * len) m[b] = 1'b1;
    end
    return m;
  endfunction

  // ascii upper to lower case, other codes unchanged
  function automatic logic [BYTE_W-1:0] fold_lower(input logic [BYTE_W-1:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

### rtl/core/sttscan_in_if.sv
// ----------------------------------------------------------------------------
// sttscan_in_if
// byte request channel: valid, ready and one file byte with its last flag
// ----------------------------------------------------------------------------
interface sttscan_in_if;
  import sttscan_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

### rtl/core/sttscan_out_if.sv
// ----------------------------------------------------------------------------
// sttscan_out_if
// result request channel: valid, ready and the per-file verdict
// ----------------------------------------------------------------------------
interface sttscan_out_if;
  import sttscan_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 suspicious;
  logic [PAT_COUNT-1:0] match_mask;
  logic [COUNT_W-1:0]   match_count;

  modport source (output valid, output suspicious, output match_mask,
                  output match_count, input ready);
  modport sink   (input valid, input suspicious, input match_mask,
                  input match_count, output ready);
endinterface

### rtl/core/script_token_threshold_scanner.sv
// ----------------------------------------------------------------------------
// script_token_threshold_scanner
// case-insensitive multi-pattern command scan over a file's byte stream,
// one verdict per file on the byte marked last
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in_chan | sink      | valid / ready        | data_byte, last
//  out_chan| source    | valid / ready        | suspicious, match_mask, match_count
//  cfg     | apb slave | psel, penable, pready| paddr, pwdata, prdata
//
//  one byte per cycle sustained unless a last byte is blocked: a byte is
//  registered on acceptance and, when the stage fires, folded, compared and used to update the scan state in one pass
//  result is registered onto out_chan when its last byte fires from the stage
//  only a last byte blocked by an untaken result stalls the input; ordinary
//  bytes keep flowing while a result waits
//  synchronous active-low reset clears the history, mask, counter and both
//  stage valids; registers return to threshold 2, scan limit 1 MiB
// ----------------------------------------------------------------------------
module script_token_threshold_scanner (
  input  logic                               clk,
  input  logic                               rst_n,
  sttscan_in_if.sink                         in_chan,
  sttscan_out_if.source                      out_chan,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sttscan_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sttscan_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sttscan_pkg::CFG_DATA_W-1:0] prdata,
  output logic                               pready
);
  import sttscan_pkg::*;

  // input stage register
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;

  // result register
  logic                 out_valid_r;
  logic                 out_susp_r;
  logic [PAT_COUNT-1:0] out_mask_r;
  logic [COUNT_W-1:0]   out_count_r;

  logic    s1_stall;
  logic    s1_fire;
  logic    in_take;
  step_t   step;
  cfg_t    cfg;
  result_t result;

  sttscan_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // a last byte waits only while the previous verdict is still unclaimed
  assign s1_stall = s1_valid_r && s1_last_r && out_valid_r && !out_chan.ready;
  assign s1_fire  = s1_valid_r && !s1_stall;

  assign in_chan.ready = !s1_stall;
  assign in_take       = in_chan.valid && !s1_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_chan.data_byte;
      s1_last_r <= in_chan.last;
    end
  end

  assign step.valid     = s1_fire;
  assign step.data_byte = s1_byte_r;
  assign step.last      = s1_last_r;

  sttscan_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .cfg    (cfg),
    .result (result)
  );

  // verdict register, loaded only by a last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_susp_r  <= result.suspicious;
      out_mask_r  <= result.match_mask;
      out_count_r <= result.match_count;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.suspicious  = out_susp_r;
  assign out_chan.match_mask  = out_mask_r;
  assign out_chan.match_count = out_count_r;

`ifndef NO_ASSERTIONS
  a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> COUNT_W'($countones(out_mask_r)) == out_count_r)
    else $error("pattern count disagrees with mask");

  a_blocked_last_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_last_r && out_valid_r && !out_chan.ready |-> !in_chan.ready)
    else $error("input taken while a last byte is blocked");

  a_no_verdict_without_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_last_r))
    else $error("verdict raised without a last byte");
`endif

endmodule

### rtl/core/sttscan_cfg.sv
// ----------------------------------------------------------------------------
// sttscan_cfg
// apb register file: match threshold and scan limit
// ----------------------------------------------------------------------------
module sttscan_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sttscan_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sttscan_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sttscan_pkg::CFG_DATA_W-1:0] prdata,
  output logic                               pready,
  output sttscan_pkg::cfg_t                  cfg
);
  import sttscan_pkg::*;

  logic [THR_W-1:0]   thr_r;
  logic [LIMIT_W-1:0] limit_r;
  logic               wr_en;
  cfg_reg_t           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  // byte lanes ignored, word address picks the register
  assign reg_sel = cfg_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THR_RESET;
      limit_r <= LIMIT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_THRESHOLD:  thr_r   <= pwdata[THR_W-1:0];
        REG_SCAN_LIMIT: limit_r <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_THRESHOLD:  prdata = CFG_DATA_W'(thr_r);
      REG_SCAN_LIMIT: prdata = CFG_DATA_W'(limit_r);
      default:        prdata = '0;
    endcase
  end

  assign cfg.match_threshold = thr_r;
  assign cfg.scan_limit      = limit_r;

endmodule

### rtl/core/sttscan_match.sv
// ----------------------------------------------------------------------------
// sttscan_match
// parallel comparator bank: window tail against each command pattern
// ----------------------------------------------------------------------------
module sttscan_match (
  input  logic [sttscan_pkg::WIN_W-1:0]     window,
  output logic [sttscan_pkg::PAT_COUNT-1:0] hits
);
  import sttscan_pkg::*;

  for (genvar p = 0; p < PAT_COUNT; p++) begin : g_pat
    localparam logic [WIN_W-1:0] MASK = pat_mask(PAT_LEN[p]);
    // masked xor is zero only where every compared byte agrees
    assign hits[p] = ((window ^ PAT_TEXT[p]) & MASK) == '0;
  end

endmodule

### rtl/core/sttscan_state.sv
// ----------------------------------------------------------------------------
// sttscan_state
// per-file scan state: byte history, sticky pattern mask, byte counter;
// forms the verdict on the last byte and clears for the next file
// ----------------------------------------------------------------------------
module sttscan_state (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sttscan_pkg::step_t    step,
  input  sttscan_pkg::cfg_t     cfg,
  output sttscan_pkg::result_t  result
);
  import sttscan_pkg::*;

  logic [HIST_W-1:0]    recent_r, recent_nxt;
  logic [PAT_COUNT-1:0] seen_r, seen_nxt;
  logic [LIMIT_W-1:0]   taken_r, taken_nxt;

  logic                 counting;
  logic [WIN_W-1:0]     window;
  logic [PAT_COUNT-1:0] hits;
  logic [PAT_COUNT-1:0] seen_upd;
  logic [LIMIT_W-1:0]   taken_upd;
  logic [HIST_W-1:0]    recent_upd;
  logic [COUNT_W-1:0]   count;

  // bytes beyond the scan limit leave the history untouched
  assign counting = taken_r < cfg.scan_limit;
  assign window   = {recent_r, fold_lower(step.data_byte)};

  sttscan_match u_match (
    .window (window),
    .hits   (hits)
  );

  assign seen_upd   = counting ? (seen_r | hits) : seen_r;
  assign taken_upd  = taken_r + LIMIT_W'(counting);
  assign recent_upd = counting ? window[HIST_W-1:0] : recent_r;

  always_comb begin
    count = '0;
    for (int i = 0; i < PAT_COUNT; i++) begin
      count = count + COUNT_W'(seen_upd[i]);
    end
  end

  assign result.match_mask  = seen_upd;
  assign result.match_count = count;
  assign result.suspicious  = (taken_upd != '0) &&
                              (count >= COUNT_W'(cfg.match_threshold));

  always_comb begin
    recent_nxt = recent_r;
    seen_nxt   = seen_r;
    taken_nxt  = taken_r;
    if (step.valid) begin
      if (step.last) begin
        recent_nxt = '0;
        seen_nxt   = '0;
        taken_nxt  = '0;
      end else begin
        recent_nxt = recent_upd;
        seen_nxt   = seen_upd;
        taken_nxt  = taken_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '0;
      seen_r   <= '0;
      taken_r  <= '0;
    end else begin
      recent_r <= recent_nxt;
      seen_r   <= seen_nxt;
      taken_r  <= taken_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step.valid && step.last |=> seen_r == '0 && taken_r == '0 && recent_r == '0)
    else $error("scan state not cleared after last byte");

  a_mask_needs_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r != '0 |-> taken_r != '0)
    else $error("pattern seen with no byte counted");
`endif

endmodule

### test/script_token_threshold_scanner_tb.sv
// ----------------------------------------------------------------------------
// script_token_threshold_scanner_tb
// self-checking bench for the script token threshold scanner: files of bytes
// go in over the input channel, each last byte's verdict is compared against
// a behavioural scan kept inside the bench, and both registers are written
// and read back over the apb port between files
// ----------------------------------------------------------------------------
module script_token_threshold_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sttscan_pkg::*;

  localparam int QUIET_LIMIT  = 500;   // cycles with no request before giving up
  localparam int SETTLE_TICKS = 4;     // a byte may still sit in the stage
  localparam int TAIL_TICKS   = 8;

  logic clk = 1'b0;
  logic rst_n;

  // apb side
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  sttscan_in_if  in_bus ();
  sttscan_out_if out_bus ();

  script_token_threshold_scanner dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  // command words in table order, lower case
  string cmd_words [PAT_COUNT] = '{
    "invoke-expression", "iex ", "downloadstring", "downloadfile",
    "-encodedcommand", " -enc ", "frombase64string", "-windowstyle hidden",
    "-executionpolicy bypass", "net.webclient"
  };

  // characters that often sit next to command words, for near misses
  string near_chars = " -.iexnd";

  // ---------------------------------------------------------------------------
  // bench copy of the scanner state and registers
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0]    hist_bytes [WINDOW_BYTES-1];  // highest index newest
  logic [PAT_COUNT-1:0] seen_cmds;
  logic [LIMIT_W-1:0]   counted_bytes;
  logic [THR_W-1:0]     thr_set;
  logic [LIMIT_W-1:0]   limit_set;

  result_t              verdicts_due [$];

  // bookkeeping
  int unsigned          fault_count     = 0;
  int unsigned          verdicts_checked = 0;
  int unsigned          bytes_sent      = 0;
  int unsigned          files_sent      = 0;
  int unsigned          flagged_files   = 0;
  logic [PAT_COUNT-1:0] cmds_hit_union  = '0;

  // idling switches, one per side
  bit in_gaps_on    = 1'b1;
  bit out_stalls_on = 1'b1;

  logic [BYTE_W-1:0] file_bytes [$];

  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void clear_scan_state();
    for (int i = 0; i < WINDOW_BYTES - 1; i++) hist_bytes[i] = '0;
    seen_cmds     = '0;
    counted_bytes = '0;
  endfunction

  // one accepted byte: fold, shift, compare every command word against the
  // newest bytes, and on last queue the verdict and start afresh
  function automatic void fold_and_scan(input logic [BYTE_W-1:0] raw,
                                        input logic is_last);
    logic [BYTE_W-1:0] win [WINDOW_BYTES];
    logic [BYTE_W-1:0] c;
    int                span;
    int                base;
    bit                hit;
    int                hits;
    result_t           v;
    if (counted_bytes < limit_set) begin
      c = raw;
      if (c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
      for (int i = 0; i < WINDOW_BYTES - 1; i++) win[i] = hist_bytes[i];
      win[WINDOW_BYTES-1] = c;
      for (int p = 0; p < PAT_COUNT; p++) begin
        span = cmd_words[p].len();
        base = WINDOW_BYTES - span;
        hit  = 1'b1;
        for (int k = 0; k < span; k++) begin
          if (win[base+k] != cmd_words[p].getc(k)) hit = 1'b0;
        end
        if (hit) seen_cmds[p] = 1'b1;
      end
      for (int i = 0; i < WINDOW_BYTES - 1; i++) hist_bytes[i] = win[i+1];
      counted_bytes = counted_bytes + 1'b1;
    end
    if (is_last) begin
      hits          = $countones(seen_cmds);
      v.suspicious  = (counted_bytes != 0) && (hits >= thr_set);
      v.match_mask  = seen_cmds;
      v.match_count = COUNT_W'(hits);
      verdicts_due.push_back(v);
      cmds_hit_union = cmds_hit_union | seen_cmds;
      if (v.suspicious) flagged_files++;
      clear_scan_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side: ready with random stall bursts, driven on the falling edge
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left    = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_bus.ready = 1'b0;
        stall_left--;
      end else if (out_stalls_on && $urandom_range(0, 5) == 0) begin
        // start a stall burst; stall_left holds the rest of it
        out_bus.ready = 1'b0;
        stall_left    = $urandom_range(0, 2);
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  // every accepted verdict against the oldest one still due
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      verdicts_checked++;
      if (verdicts_due.size() == 0) begin
        note_fault($sformatf("verdict with nothing due: sus=%0b mask=%b count=%0d",
                             out_bus.suspicious, out_bus.match_mask,
                             out_bus.match_count));
      end else begin
        want = verdicts_due.pop_front();
        if (out_bus.suspicious !== want.suspicious ||
            out_bus.match_mask !== want.match_mask ||
            out_bus.match_count !== want.match_count) begin
          note_fault($sformatf({"verdict %0d: expected sus=%0b mask=%b count=%0d, ",
                                "got sus=%0b mask=%b count=%0d"},
                               verdicts_checked, want.suspicious, want.match_mask,
                               want.match_count, out_bus.suspicious,
                               out_bus.match_mask, out_bus.match_count));
        end
      end
    end
  end

  // watchdog: a long run of cycles with no request anywhere means a hang
  always @(posedge clk) begin
    int unsigned quiet;
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable && pready) || !rst_n) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no request for %0d cycles, %0d verdicts still due",
               quiet, verdicts_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input channel and apb helpers
  // ---------------------------------------------------------------------------

  // one byte request; valid stays high into the next call unless a gap falls
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic is_last);
    int gap;
    @(negedge clk);
    if (in_gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid     = 1'b1;
    in_bus.data_byte = b;
    in_bus.last      = is_last;
    do @(posedge clk); while (!in_bus.ready);
    bytes_sent++;
    fold_and_scan(b, is_last);
  endtask

  // send the planned file, last on its final byte
  task automatic send_file();
    if (file_bytes.size() == 0) file_bytes.push_back(8'($urandom_range(0, 255)));
    foreach (file_bytes[i]) push_byte(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
    files_sent++;
  endtask

  // drop valid, let every due verdict arrive and the stage empty
  task automatic settle(input int ticks);
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (ticks) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_THRESHOLD:  thr_set   = value[THR_W-1:0];
      REG_SCAN_LIMIT: limit_set = value[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // read back and compare with the bench copy
  task automatic cfg_check(input cfg_reg_t idx);
    logic [CFG_DATA_W-1:0] got;
    logic [CFG_DATA_W-1:0] want;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got  = prdata;
    want = (idx == REG_THRESHOLD) ? CFG_DATA_W'(thr_set) : CFG_DATA_W'(limit_set);
    if (got !== want) begin
      note_fault($sformatf("register %s reads %0h, expected %0h", idx.name(), got, want));
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // registers only change with the block idle and between files
  task automatic apply_settings(input logic [THR_W-1:0] thr,
                                input logic [LIMIT_W-1:0] lim);
    settle(SETTLE_TICKS);
    cfg_write(REG_THRESHOLD, CFG_DATA_W'(thr));
    cfg_write(REG_SCAN_LIMIT, CFG_DATA_W'(lim));
    cfg_check(REG_THRESHOLD);
    cfg_check(REG_SCAN_LIMIT);
  endtask

  // ---------------------------------------------------------------------------
  // file planning
  // ---------------------------------------------------------------------------

  // random bytes, a quarter of them taken from the near-miss characters
  function automatic void plan_noise(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        file_bytes.push_back(near_chars.getc($urandom_range(0, near_chars.len() - 1)));
      else
        file_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // command word in random case; damage 1 flips one bit (never the case bit)
  // of one character, damage 2 cuts the word short
  function automatic void plan_word(input int p, input int damage);
    logic [BYTE_W-1:0] c;
    int                span;
    int                spoil_at;
    int                flip;
    span     = cmd_words[p].len();
    spoil_at = -1;
    if (damage == 1) spoil_at = $urandom_range(0, span - 1);
    if (damage == 2) span = $urandom_range(1, span - 1);
    for (int k = 0; k < span; k++) begin
      c = cmd_words[p].getc(k);
      if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) c = c - 8'h20;
      if (k == spoil_at) begin
        flip = $urandom_range(0, 6);
        if (flip >= 5) flip++;
        c = c ^ (8'h01 << flip);
      end
      file_bytes.push_back(c);
    end
  endfunction

  // one random file: mostly short with a few fragments, now and then dense
  task automatic random_file(input int dense_one_in);
    int pick;
    if ($urandom_range(1, dense_one_in) == 1) begin
      repeat ($urandom_range(5, 10)) begin
        plan_noise($urandom_range(0, 2));
        plan_word($urandom_range(0, PAT_COUNT - 1), 0);
      end
    end else begin
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 9);
        if (pick < 4)      plan_word($urandom_range(0, PAT_COUNT - 1), 0);
        else if (pick < 6) plan_word($urandom_range(0, PAT_COUNT - 1), $urandom_range(1, 2));
        else               plan_noise($urandom_range(1, 10));
      end
    end
    send_file();
  endtask

  task automatic scan_files(input int budget, input int dense_one_in);
    int unsigned from;
    from = bytes_sent;
    while (bytes_sent - from < budget) random_file(dense_one_in);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers come out of reset at threshold 2 and a 1 MiB limit
  task automatic test_register_reset();
    cfg_check(REG_THRESHOLD);
    cfg_check(REG_SCAN_LIMIT);
  endtask

  // byte extremes and the edges of the upper case range, then a one-byte file
  task automatic test_byte_extremes();
    file_bytes = '{8'h00, 8'hFF, 8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};
    send_file();
    file_bytes = '{8'h80};
    send_file();
  endtask

  // threshold zero flags any file with a counted byte; a zero limit counts
  // nothing, so even threshold zero gives a clean verdict
  task automatic test_threshold_zero_and_empty_limit();
    apply_settings(4'd0, limit_set);
    file_bytes = '{8'h7F};
    send_file();
    apply_settings(4'd0, '0);
    plan_word(1, 0);
    send_file();
  endtask

  // limit of four bytes: a word ending on the fourth byte counts, one that
  // ends on the fifth does not, and bytes past the limit are dropped
  task automatic test_limit_boundary();
    apply_settings(4'd1, LIMIT_W'(4));
    plan_word(1, 0);
    plan_noise(2);
    send_file();
    file_bytes.push_back("x");
    plan_word(1, 0);
    send_file();
  endtask

  // random files across several register settings, extremes among them
  task automatic test_mixed_scan();
    // all ten words in one file first, then the default settings
    apply_settings(THR_RESET, LIMIT_RESET);
    for (int p = 0; p < PAT_COUNT; p++) begin
      plan_noise(1);
      plan_word(p, 0);
    end
    send_file();
    scan_files(200, 8);

    // largest limit, threshold out of reach
    apply_settings(4'd15, {LIMIT_W{1'b1}});
    scan_files(100, 4);

    // short limits so the counter saturates inside most files
    apply_settings(THR_W'($urandom_range(0, 11)), LIMIT_W'($urandom_range(1, 48)));
    scan_files(90, 8);
    apply_settings(THR_W'($urandom_range(0, 3)), LIMIT_W'($urandom_range(1, 24)));
    scan_files(80, 8);

    // dense files against a high threshold, input side without gaps
    in_gaps_on = 1'b0;
    apply_settings(4'd10, LIMIT_RESET);
    scan_files(140, 2);
    in_gaps_on = 1'b1;

    // anything goes
    apply_settings(THR_W'($urandom_range(0, 15)), LIMIT_W'($urandom_range(1, 1 << 20)));
    scan_files(100, 6);
  endtask

  // closing stretch at full rate on both sides
  task automatic test_steady_stream();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    apply_settings(4'd3, LIMIT_RESET);
    scan_files(150, 6);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    in_bus.last      = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    thr_set          = THR_RESET;
    limit_set        = LIMIT_RESET;
    clear_scan_state();

    // synchronous reset, released on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_register_reset();
    test_byte_extremes();
    test_threshold_zero_and_empty_limit();
    test_limit_boundary();
    test_mixed_scan();
    test_steady_stream();

    // let the last verdicts through, then a few spare cycles
    settle(TAIL_TICKS);

    $display("covered %0d bytes in %0d files, %0d verdicts checked, %0d flagged",
             bytes_sent, files_sent, verdicts_checked, flagged_files);
    $display("command words seen over the run: %b, mismatches: %0d",
             cmds_hit_union, fault_count);
    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
